[rtl/bqhp_pkg.sv]
// Shared types, constants and a helper function for the biquad high-pass filter.
package bqhp_pkg;

	// Field and datapath widths.
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 32;
	localparam int ACC_W    = 48;
	localparam int YQ_W     = 32;
	localparam int DIGIT_W  = 8;
	localparam int X_DIGITS = SAMPLE_W / DIGIT_W;
	localparam int Y_DIGITS = YQ_W / DIGIT_W;
	localparam int PROD_W   = COEF_W + DIGIT_W + 1;
	localparam int FBACC_W  = COEF_W + YQ_W;
	localparam int SUM_W    = FBACC_W + 2;
	localparam int CNT_W    = 2;

	// Configuration port.
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int REGIDX_W = 3;

	localparam logic [REGIDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [REGIDX_W-1:0] REG_B0     = 3'd1;
	localparam logic [REGIDX_W-1:0] REG_B1     = 3'd2;
	localparam logic [REGIDX_W-1:0] REG_B2     = 3'd3;
	localparam logic [REGIDX_W-1:0] REG_A1     = 3'd4;
	localparam logic [REGIDX_W-1:0] REG_A2     = 3'd5;

	// Input transaction payload.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       frame_last;
	} bqhp_x_t;

	// Output transaction payload.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       frame_last_out;
	} bqhp_y_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULX,
		ST_SUMY,
		ST_MULY,
		ST_UPD,
		ST_DRAIN
	} bqhp_state_t;

	// Saturate a wide signed sum to the accumulator range.
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-ACC_W:0] top;
		top = v[SUM_W-1:ACC_W-1];
		if ((top == '0) || (top == '1)) begin
			return v[ACC_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			return {1'b0, {(ACC_W-1){1'b1}}};
		end
	endfunction

endpackage

[rtl/biquad_highpass_filter.sv]
// Top level of the biquad high-pass filter: register file, sequencer and digit-serial datapath.
//
//  channel  direction  handshake                 payload
//  x        in         x_valid / x_ready         bqhp_x_t (sample_in, frame_last)
//  y        out        y_valid / y_ready         bqhp_y_t (sample_out, frame_last_out)
//  cfg      in         psel/penable/pwrite       paddr, pwdata, prdata
//
// A filtered sample passes from acceptance to the output register in these steps: two 8-bit
// digits of the sample through the three feed-forward multipliers, the output sum, four
// 8-bit digits of the quantized output through the feedback multipliers, and the state
// update. A bypassed sample goes straight to DRAIN. x_ready is high only in IDLE, so a new
// transaction is not accepted until the previous one has been loaded into the output register.
// Reset clears the state, coefficients and output valid at once; there is no clearing pass.
// When the output register is still full at the end of a transaction, the sequencer waits
// in DRAIN until y_ready frees it.
module biquad_highpass_filter
	import bqhp_pkg::*;
#(
	parameter int COEF_FRAC_BITS = 29
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               x_valid,
	output logic               x_ready,
	input  bqhp_x_t            x_data,
	output logic               y_valid,
	input  logic               y_ready,
	output bqhp_y_t            y_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam int FB_SHIFT = COEF_FRAC_BITS - 16;
	localparam logic [ACC_W-1:0] FRAC_MASK = (ACC_W'(1) << COEF_FRAC_BITS) - ACC_W'(1);

	// Configuration registers.
	logic                     en_q;
	logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic [REGIDX_W-1:0]      reg_idx;
	logic                     cfg_wr;

	// Filter state.
	logic signed [ACC_W-1:0] d1_q, d2_q;

	// Sequencer.
	bqhp_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             x_accept;
	logic             out_free;
	logic             out_load;

	// Datapath registers.
	logic [SAMPLE_W-1:0]         x_sr_q;
	logic [YQ_W-1:0]             yq_sr_q;
	logic signed [ACC_W-1:0]     p0_q, p1_q, p2_q, y_q;
	logic signed [FBACC_W-1:0]   fb1_q, fb2_q;
	logic signed [SAMPLE_W-1:0]  res_q;
	logic                        last_q;
	logic                        out_valid_q;
	bqhp_y_t                     out_q;

	// Datapath logic.
	logic [DIGIT_W-1:0]         digit;
	logic signed [DIGIT_W:0]    op;
	logic signed [COEF_W-1:0]   mc0, mc1;
	logic signed [PROD_W-1:0]   m0, m1, m2;
	logic signed [ACC_W-1:0]    y_sat;
	logic signed [ACC_W-1:0]    s_full;
	logic signed [SAMPLE_W-1:0] s_clamp;
	logic signed [ACC_W-1:0]    n1, n2;
	logic signed [FBACC_W-1:0]  fbs1, fbs2;

	assign pready   = 1'b1;
	assign reg_idx  = paddr[ADDR_W-1:2];
	assign cfg_wr   = psel && penable && pwrite;
	assign x_accept = x_valid && x_ready;
	assign out_free = !out_valid_q || y_ready;
	assign y_valid  = out_valid_q;
	assign y_data   = out_q;

	// Register read mux.
	always_comb begin
		unique case (reg_idx)
			REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, en_q};
			REG_B0:     prdata = b0_q;
			REG_B1:     prdata = b1_q;
			REG_B2:     prdata = b2_q;
			REG_A1:     prdata = a1_q;
			REG_A2:     prdata = a2_q;
			default:    prdata = '0;
		endcase
	end

	// Register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			b0_q <= '0;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ENABLE: en_q <= pwdata[0];
				REG_B0:     b0_q <= pwdata;
				REG_B1:     b1_q <= pwdata;
				REG_B2:     b2_q <= pwdata;
				REG_A1:     a1_q <= pwdata;
				REG_A2:     a2_q <= pwdata;
				default:    ;
			endcase
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, input ready and output load.
	always_comb begin
		state_d  = state_q;
		x_ready  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				x_ready = 1'b1;
				if (x_valid) begin
					state_d = en_q ? ST_MULX : ST_DRAIN;
				end
			end
			ST_MULX: begin
				if (cnt_q == CNT_W'(X_DIGITS - 1)) begin
					state_d = ST_SUMY;
				end
			end
			ST_SUMY: begin
				state_d = ST_MULY;
			end
			ST_MULY: begin
				if (cnt_q == CNT_W'(Y_DIGITS - 1)) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Digit counter for the serial multiply phases.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_MULX || state_q == ST_MULY) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	// Current multiplier digit, most significant first; the top digit carries the sign.
	always_comb begin
		digit = (state_q == ST_MULY) ? yq_sr_q[YQ_W-1 -: DIGIT_W] : x_sr_q[SAMPLE_W-1 -: DIGIT_W];
		op    = {(cnt_q == '0) && digit[DIGIT_W-1], digit};
	end

	// Three coefficient-by-digit multipliers; the first two are shared with the feedback phase.
	assign mc0 = (state_q == ST_MULY) ? a1_q : b0_q;
	assign mc1 = (state_q == ST_MULY) ? a2_q : b1_q;
	assign m0  = mc0 * op;
	assign m1  = mc1 * op;
	assign m2  = b2_q * op;

	// Output sum y = b0*x + z1, saturated.
	assign y_sat = sat_acc(SUM_W'(p0_q) + SUM_W'(d1_q));

	// Output sample: truncate toward zero, then clamp to 16 bits.
	always_comb begin
		s_full = (y_q >>> COEF_FRAC_BITS)
			+ $signed(ACC_W'(y_q[ACC_W-1] && ((y_q & FRAC_MASK) != '0)));
		if ((s_full[ACC_W-1:SAMPLE_W-1] == '0) || (s_full[ACC_W-1:SAMPLE_W-1] == '1)) begin
			s_clamp = s_full[SAMPLE_W-1:0];
		end else if (s_full[ACC_W-1]) begin
			s_clamp = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			s_clamp = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	// New delay values from the feedback products.
	assign fbs1 = fb1_q >>> FB_SHIFT;
	assign fbs2 = fb2_q >>> FB_SHIFT;
	assign n1   = sat_acc(SUM_W'(p1_q) - SUM_W'(fbs1) + SUM_W'(d2_q));
	assign n2   = sat_acc(SUM_W'(p2_q) - SUM_W'(fbs2));

	// Datapath payload registers.
	always_ff @(posedge clk) begin
		if (x_accept) begin
			x_sr_q <= x_data.sample_in;
			res_q  <= x_data.sample_in;
			last_q <= x_data.frame_last;
			p0_q   <= '0;
			p1_q   <= '0;
			p2_q   <= '0;
		end
		if (state_q == ST_MULX) begin
			x_sr_q <= {x_sr_q[SAMPLE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
			p0_q   <= (p0_q <<< DIGIT_W) + ACC_W'(m0);
			p1_q   <= (p1_q <<< DIGIT_W) + ACC_W'(m1);
			p2_q   <= (p2_q <<< DIGIT_W) + ACC_W'(m2);
		end
		if (state_q == ST_SUMY) begin
			y_q     <= y_sat;
			yq_sr_q <= y_sat[ACC_W-1:ACC_W-YQ_W];
			fb1_q   <= '0;
			fb2_q   <= '0;
		end
		if (state_q == ST_MULY) begin
			yq_sr_q <= {yq_sr_q[YQ_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
			fb1_q   <= (fb1_q <<< DIGIT_W) + FBACC_W'(m0);
			fb2_q   <= (fb2_q <<< DIGIT_W) + FBACC_W'(m1);
			if (cnt_q == '0) begin
				res_q <= s_clamp;
			end
		end
		if (out_load) begin
			out_q.sample_out     <= res_q;
			out_q.frame_last_out <= last_q;
		end
	end

	// Delay line update at the end of a filtered transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (state_q == ST_UPD) begin
			d1_q <= n1;
			d2_q <= n2;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (y_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A filtered sample starts the feed-forward multiply on the next cycle.
	a_filter_start: assert property (@(posedge clk) disable iff (!arst_n)
		(x_accept && en_q) |=> (state_q == ST_MULX))
		else $error("filtered transaction did not enter the multiply phase");

	// The delay line changes only in the update state.
	a_delay_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_UPD) |=> ($stable(d1_q) && $stable(d2_q)))
		else $error("delay line changed outside the update state");

	// The output register is loaded only from the update or drain state.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_UPD || $past(state_q) == ST_DRAIN))
		else $error("output valid rose without a finished transaction");

	// The digit counter never runs past the operand length.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULX) |-> (cnt_q < CNT_W'(X_DIGITS)))
		else $error("sample digit counter out of range");

endmodule
